FILE: hdl/spf_sieve_factorizer_assert.svh
// Assertion macros for the sieve factorizer.
`ifndef SPF_SIEVE_FACTORIZER_ASSERT_SVH
`define SPF_SIEVE_FACTORIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SPF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SPF_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: hdl/spf_pkg.sv
//------------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the sieve factorizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package spf_pkg;
  localparam int ValW = 20;
  localparam int LimW = 21;
  localparam int CntW = 8;
  localparam int MaxResults = 19;
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNBUILT = 2'd2
  } status_t;
  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_FACTOR = 1'b1;
endpackage

FILE: hdl/spf_ram.sv
//------------------------------------------------------------------------------
// spf_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module spf_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/spf_divider.sv
//------------------------------------------------------------------------------
// spf_divider
// Radix-2 restoring divider producing quotient and remainder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module spf_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [spf_pkg::ValW-1:0] dividend,
  input  logic [spf_pkg::ValW-1:0] divisor,
  output logic                    done,
  output logic [spf_pkg::ValW-1:0] quotient,
  output logic [spf_pkg::ValW-1:0] remainder
);
  localparam int W = spf_pkg::ValW;
  logic [W-1:0] dvs;
  logic [$clog2(W+1)-1:0] cnt;
  logic running;
  logic [W:0] trial;
  logic [W-1:0] shifted;
  always_comb begin
    shifted = {remainder[W-2:0], quotient[W-1]};
    trial = {1'b0, shifted} - {1'b0, dvs};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        quotient <= dividend;
        remainder <= '0;
        dvs <= divisor;
        cnt <= '0;
      end else if (running) begin
        if (trial[W]) begin
          remainder <= shifted;
          quotient <= {quotient[W-2:0], 1'b0};
        end else begin
          remainder <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(W+1))'(W-1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/spf_sieve_factorizer.sv
//------------------------------------------------------------------------------
// spf_sieve_factorizer
// Linear-sieve smallest-prime-factor table builder and table-walk factorizer.
//------------------------------------------------------------------------------
// Factorize: errors, zero and one give a single registered beat on acceptance;
// otherwise each factor passes read, read wait, the divider and emit, the
// last beat leaving as busy falls. Build issues no beats: a clear pass over
// every entry, then per entry a read, a check and a walk over primes tried.
// Results cannot be stalled; each beat lasts one cycle. Reset clears the built
// flag and prime count and restores the default limit; the RAMs keep contents.
`timescale 1ns / 1ps
module spf_sieve_factorizer #(
  parameter int SIEVE_SIZE = 1048576,
  parameter int PRIME_LIST_DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic [19:0]              value,
  input  logic                     cfg_we,
  input  logic [20:0]              cfg_wdata,
  output logic                     strobe,
  output logic [19:0]              prime_factor,
  output logic                     is_last,
  output logic [7:0]               divisor_count,
  output logic [1:0]               status
);
  localparam int AW = $clog2(SIEVE_SIZE);
  localparam int PW = $clog2(PRIME_LIST_DEPTH);
  localparam int CW = $clog2(PRIME_LIST_DEPTH + 1);
  // Wide enough to hold SIEVE_SIZE and any product i*p below 2*SIEVE_SIZE.
  localparam int LW = $clog2(SIEVE_SIZE) + 2;
  localparam int VW = spf_pkg::ValW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_I_RD, S_I_CHK, S_J_RD, S_J_CHK, S_F_RD, S_F_WAIT,
    S_F_DIV, S_F_EMIT
  } state_t;
  state_t state;

  logic [20:0] sieve_limit;
  logic [LW-1:0] built_limit, lim;
  logic table_built;
  logic [CW-1:0] pcount;

  // The sieve keeps only primes below lim; index and multiple use the limit
  // width, the prime index the count width, the factors the value width.
  logic [LW-1:0] i_cnt, m_val;
  logic [CW-1:0] j_cnt;
  logic [VW-1:0] spf_i, p_cur;

  // Table RAM port signals.
  logic t_we;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [VW-1:0] t_wdata, t_rdata;
  logic p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [VW-1:0] p_wdata, p_rdata;

  // Factorization state.
  logic [VW-1:0] a_val, f_p, prev;
  logic [4:0] expo, k_cnt;
  logic [7:0] count;
  logic div_start, div_done;
  logic [VW-1:0] div_q, div_r;

  spf_ram #(.WIDTH(VW), .DEPTH(SIEVE_SIZE)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );
  spf_ram #(.WIDTH(VW), .DEPTH(PRIME_LIST_DEPTH)) u_primes (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  // The divisor is taken straight from the table read, latched on start.
  spf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a_val), .divisor(t_rdata),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  assign busy = (state != S_IDLE);

  // Multiple of the current sieve index by the prime just read from the list.
  assign m_val = LW'(i_cnt) * LW'(p_rdata);

  // Saturated limit used when a build starts.
  logic [LW-1:0] sat_lim;
  always_comb begin
    if (sieve_limit < 21'd16) sat_lim = LW'(16);
    else if (32'(sieve_limit) > 32'(SIEVE_SIZE)) sat_lim = LW'(SIEVE_SIZE);
    else sat_lim = LW'(sieve_limit);
  end

  // Saturating count update: count * (expo + 1), with small operands.
  function automatic logic [7:0] mul_sat(input logic [7:0] c, input logic [4:0] e);
    logic [13:0] prod;
    prod = 14'(c) * 14'(e + 5'd1);
    return (prod > 14'd255) ? 8'd255 : prod[7:0];
  endfunction

  // Table address mux: the clear pass, the prime check and the marking step write,
  // reads come from the sieve index or from the value being factorized.
  always_comb begin
    t_we = 1'b0;
    t_waddr = i_cnt[AW-1:0];
    t_wdata = '0;
    t_raddr = i_cnt[AW-1:0];
    p_we = 1'b0;
    p_waddr = pcount[PW-1:0];
    p_wdata = i_cnt[VW-1:0];
    p_raddr = j_cnt[PW-1:0];
    div_start = 1'b0;
    case (state)
      S_CLR: t_we = 1'b1;
      S_I_CHK: begin
        if (t_rdata == '0) begin
          t_we = 1'b1;
          t_wdata = i_cnt[VW-1:0];
          p_we = (pcount < CW'(PRIME_LIST_DEPTH));
        end
      end
      S_J_CHK: begin
        t_waddr = m_val[AW-1:0];
        t_wdata = p_rdata;
        t_we = !(spf_i < p_rdata || m_val >= lim);
      end
      S_F_RD: t_raddr = a_val[AW-1:0];
      S_F_WAIT: div_start = (t_rdata >= VW'(2));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sieve_limit <= 21'd1048576;
      built_limit <= '0;
      table_built <= 1'b0;
      pcount <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) sieve_limit <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (func == spf_pkg::FUNC_BUILD) begin
              lim <= sat_lim;
              i_cnt <= '0;
              pcount <= '0;
              state <= S_CLR;
            end else begin
              prime_factor <= '0;
              is_last <= 1'b1;
              if (!table_built) begin
                strobe <= 1'b1;
                divisor_count <= 8'd0;
                status <= spf_pkg::ST_UNBUILT;
              end else if (LW'(value) >= built_limit) begin
                strobe <= 1'b1;
                divisor_count <= 8'd0;
                status <= spf_pkg::ST_RANGE;
              end else if (value < 20'd2) begin
                strobe <= 1'b1;
                divisor_count <= 8'd1;
                status <= spf_pkg::ST_OK;
              end else begin
                a_val <= value;
                prev <= '0;
                expo <= '0;
                count <= 8'd1;
                k_cnt <= '0;
                state <= S_F_RD;
              end
            end
          end
        end
        S_CLR: begin
          if (i_cnt == lim - 1'b1) begin
            i_cnt <= LW'(2);
            state <= S_I_RD;
          end else i_cnt <= i_cnt + 1'b1;
        end
        S_I_RD: state <= S_I_CHK;
        S_I_CHK: begin
          if (t_rdata == '0) begin
            spf_i <= i_cnt[VW-1:0];
            if (pcount < CW'(PRIME_LIST_DEPTH)) pcount <= pcount + 1'b1;
          end else spf_i <= t_rdata;
          j_cnt <= '0;
          state <= S_J_RD;
        end
        S_J_RD: begin
          if (j_cnt >= pcount) begin
            if (i_cnt == lim - 1'b1) begin
              built_limit <= lim;
              table_built <= 1'b1;
              state <= S_IDLE;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              state <= S_I_RD;
            end
          end else begin
            state <= S_J_CHK;
          end
        end
        S_J_CHK: begin
          if (t_we) begin
            j_cnt <= j_cnt + 1'b1;
            state <= S_J_RD;
          end else begin
            j_cnt <= pcount;
            state <= S_J_RD;
          end
        end
        S_F_RD: state <= S_F_WAIT;
        S_F_WAIT: begin
          if (t_rdata < VW'(2)) begin
            f_p <= a_val;
            a_val <= VW'(1);
            state <= S_F_EMIT;
          end else begin
            f_p <= t_rdata;
            state <= S_F_DIV;
          end
        end
        S_F_DIV: begin
          if (div_done) begin
            if (div_r != '0) begin
              f_p <= a_val;
              a_val <= VW'(1);
            end else a_val <= div_q;
            state <= S_F_EMIT;
          end
        end
        S_F_EMIT: begin : f_emit
          logic [4:0] e_n;
          logic [7:0] c_n;
          logic done_n;
          e_n = (f_p == prev) ? expo + 1'b1 : 5'd1;
          c_n = (f_p == prev || expo == '0) ? count : mul_sat(count, expo);
          done_n = (a_val == VW'(1)) ||
                   (k_cnt == 5'(spf_pkg::MaxResults - 1));
          strobe <= 1'b1;
          prime_factor <= f_p;
          status <= spf_pkg::ST_OK;
          k_cnt <= k_cnt + 1'b1;
          expo <= e_n;
          count <= c_n;
          prev <= f_p;
          is_last <= done_n;
          divisor_count <= done_n ? mul_sat(c_n, e_n) : 8'd0;
          state <= done_n ? S_IDLE : S_F_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Both bad-entry fallbacks take the whole rest as the factor and leave one
  // behind, so the emit step sees the walk as finished.

`include "spf_sieve_factorizer_assert.svh"
  `SPF_ASSERT_IMP(a_strobe_idle, clk, rst, strobe && is_last, state == S_IDLE)
  `SPF_ASSERT_IMP(a_err_zero, clk, rst, strobe && status != spf_pkg::ST_OK,
                  prime_factor == '0 && divisor_count == 8'd0)
  `SPF_ASSERT_NXT(a_start_busy, clk, rst, start && !busy && func == spf_pkg::FUNC_BUILD,
                  busy)
endmodule
